// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/drt_pkg.sv
package drt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int MODE_W  = 1;
    localparam int RANK_W  = 4;
    localparam int SUIT_W  = 2;
    localparam int ENTRY_W = RANK_W + SUIT_W;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    down;
        logic    shift;
        logic    put_new;
        logic    put_head;
        logic    mark_found;
        logic    finish;
        status_t code;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic pend;
        logic d_valid;
        logic d_last;
        logic d_lower;
        logic d_match;
        logic found;
        logic is_remove;
    } dp_sts_t;

endpackage

// File: rtl/drt_cmd_if.sv
interface drt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [drt_pkg::MODE_W-1:0]  mode;
    logic [drt_pkg::RANK_W-1:0]  card_rank;
    logic [drt_pkg::SUIT_W-1:0]  card_suit;

    modport source (output valid, output mode, output card_rank, output card_suit,
                    input ready);
    modport sink   (input valid, input mode, input card_rank, input card_suit,
                    output ready);
endinterface

// File: rtl/drt_rsp_if.sv
interface drt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [drt_pkg::STAT_W-1:0]   status;
    logic [drt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// File: rtl/drt_ctrl.sv
module drt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [drt_pkg::MODE_W-1:0]  in_mode,
    input  drt_pkg::dp_sts_t            sts,
    output drt_pkg::ctl_cmd_t           ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HEAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fire;

    assign in_ready = (state_reg == S_IDLE) && !sts.pend;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        ctl        = '0;
        ctl.code   = drt_pkg::ST_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    ctl.load = 1'b1;
                    if (in_mode == drt_pkg::MODE_INSERT)
                    begin
                        if (sts.full)
                        begin
                            ctl.finish = 1'b1;
                            ctl.code   = drt_pkg::ST_FULL;
                        end
                        else if (sts.empty)
                        begin
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            ctl.start  = 1'b1;
                            ctl.down   = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            ctl.finish = 1'b1;
                            ctl.code   = drt_pkg::ST_MISS;
                        end
                        else
                        begin
                            ctl.start  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.d_valid)
                begin
                    if (!sts.is_remove)
                    begin
                        if (sts.d_lower)
                        begin
                            ctl.shift = 1'b1;
                            if (sts.d_last)
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        else
                        begin
                            ctl.put_new = 1'b1;
                            ctl.finish  = 1'b1;
                            ctl.code    = drt_pkg::ST_DONE;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        if (!sts.found && sts.d_match)
                        begin
                            ctl.mark_found = 1'b1;
                        end
                        else if (sts.found)
                        begin
                            ctl.shift = 1'b1;
                        end
                        if (sts.d_last)
                        begin
                            ctl.finish = 1'b1;
                            ctl.code   = (sts.found || sts.d_match) ? drt_pkg::ST_DONE
                                                                   : drt_pkg::ST_MISS;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_HEAD:
            begin
                ctl.put_head = 1'b1;
                ctl.finish   = 1'b1;
                ctl.code     = drt_pkg::ST_DONE;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/drt_datapath.sv
module drt_datapath #(
    parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  drt_pkg::ctl_cmd_t            ctl,
    output drt_pkg::dp_sts_t             sts,
    input  logic [drt_pkg::MODE_W-1:0]   in_mode,
    input  logic [drt_pkg::RANK_W-1:0]   in_rank,
    input  logic [drt_pkg::SUIT_W-1:0]   in_suit,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [drt_pkg::STAT_W-1:0]   out_status,
    output logic [drt_pkg::COUNT_W-1:0]  out_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [drt_pkg::ENTRY_W-1:0] entry_mem_reg [CAPACITY];

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                count_m1;
    logic [IW-1:0]                ptr_reg;
    logic                         issue_reg;
    logic                         issue_last;
    logic                         d_valid_reg;
    logic                         d_last_reg;
    logic [IW-1:0]                d_addr_reg;
    logic [drt_pkg::ENTRY_W-1:0]  rd_data_reg;
    logic                         found_reg;
    logic [drt_pkg::MODE_W-1:0]   mode_reg;
    logic [drt_pkg::RANK_W-1:0]   rank_reg;
    logic [drt_pkg::SUIT_W-1:0]   suit_reg;

    logic                         out_valid_reg;
    logic [drt_pkg::STAT_W-1:0]   out_status_reg;
    logic [drt_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         pend_valid_reg;
    logic [drt_pkg::STAT_W-1:0]   pend_status_reg;
    logic [drt_pkg::COUNT_W-1:0]  pend_count_reg;

    logic                         down;
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic [drt_pkg::ENTRY_W-1:0]  wr_data;
    logic [drt_pkg::ENTRY_W-1:0]  new_entry;
    logic [CW+drt_pkg::COUNT_W-1:0] count_wide;
    logic                         out_free;

    assign count_m1   = count_reg - CW'(1);
    assign down       = (mode_reg == drt_pkg::MODE_INSERT);
    assign issue_last = down ? (ptr_reg == '0) : (CW'(ptr_reg) == count_m1);
    assign new_entry  = {rank_reg, suit_reg};
    assign out_free   = !out_valid_reg || out_ready;

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(CAPACITY));
    assign sts.pend      = pend_valid_reg;
    assign sts.d_valid   = d_valid_reg;
    assign sts.d_last    = d_last_reg;
    assign sts.d_lower   = (rd_data_reg[drt_pkg::ENTRY_W-1:drt_pkg::SUIT_W] < rank_reg);
    assign sts.d_match   = (rd_data_reg[drt_pkg::ENTRY_W-1:drt_pkg::SUIT_W] == rank_reg);
    assign sts.found     = found_reg;
    assign sts.is_remove = (mode_reg == drt_pkg::MODE_REMOVE);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = d_addr_reg + IW'(1);
        wr_data = new_entry;
        if (ctl.shift)
        begin
            wr_en   = 1'b1;
            wr_addr = down ? (d_addr_reg + IW'(1)) : (d_addr_reg - IW'(1));
            wr_data = rd_data_reg;
        end
        else if (ctl.put_new)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.put_head)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.finish && (ctl.code == drt_pkg::ST_DONE))
        begin
            count_next = down ? (count_reg + CW'(1)) : count_m1;
        end
    end

    assign count_wide = {{drt_pkg::COUNT_W{1'b0}}, count_next};

    // table storage and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        if (issue_reg)
        begin
            rd_data_reg <= entry_mem_reg[ptr_reg];
        end
        d_addr_reg <= ptr_reg;
        d_last_reg <= issue_last;
        if (ctl.load)
        begin
            mode_reg <= in_mode;
            rank_reg <= in_rank;
            suit_reg <= in_suit;
        end
        if (ctl.start)
        begin
            ptr_reg <= ctl.down ? count_m1[IW-1:0] : '0;
        end
        else if (issue_reg)
        begin
            ptr_reg <= down ? (ptr_reg - IW'(1)) : (ptr_reg + IW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            d_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            d_valid_reg <= issue_reg && !ctl.finish;
            if (ctl.start)
            begin
                issue_reg <= 1'b1;
            end
            else if (ctl.finish || (issue_reg && issue_last))
            begin
                issue_reg <= 1'b0;
            end
            if (ctl.start)
            begin
                found_reg <= 1'b0;
            end
            else if (ctl.mark_found)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // result register with one holding stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.finish)
            begin
                if (out_free && !pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (pend_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            if (out_free && !pend_valid_reg)
            begin
                out_status_reg <= ctl.code;
                out_count_reg  <= count_wide[drt_pkg::COUNT_W-1:0];
            end
            else
            begin
                pend_status_reg <= ctl.code;
                pend_count_reg  <= count_wide[drt_pkg::COUNT_W-1:0];
            end
        end
        else if (pend_valid_reg && out_free)
        begin
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

// File: rtl/descending_sorted_rank_table.sv
// Keeps up to CAPACITY (rank, suit) entries in descending rank order, equal ranks in
// arrival order, in a single table memory with one write and one registered read port.
// Each command transaction (insert or remove) returns one response transaction with a
// status and the count held afterwards. The table is scanned one entry per cycle:
// an insert walks up from the tail past the held entries ranked below the new one,
// moving each of them one place; a remove walks the whole held range. An insert into
// a full table or a remove from an empty one is finished in the accepting cycle, with
// no scan. One finished response may wait on the response channel while the next
// command is taken.
module descending_sorted_rank_table #(
    parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    drt_cmd_if.sink     cmd,
    drt_rsp_if.source   rsp
);

    drt_pkg::ctl_cmd_t ctl;
    drt_pkg::dp_sts_t  sts;

    drt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .in_mode  (cmd.mode),
        .sts      (sts),
        .ctl      (ctl)
    );

    drt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_mode    (cmd.mode),
        .in_rank    (cmd.card_rank),
        .in_suit    (cmd.card_suit),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_count  (rsp.entry_count)
    );

endmodule

// File: rtl/drt_checker.sv
`include "assert_macros.svh"

module drt_checker #(
    parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [drt_pkg::STAT_W-1:0]    rsp_status,
    input logic [drt_pkg::COUNT_W-1:0]   rsp_entry_count
);

    // a command taken while a response waits blocks the next one
    `ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && cmd_ready && rsp_valid && !rsp_ready,
                 !cmd_ready)

    `ASSERT_IMPL(a_status_code, clk, rst_n, rsp_valid,
                 (rsp_status == drt_pkg::ST_DONE) || (rsp_status == drt_pkg::ST_MISS)
                 || (rsp_status == drt_pkg::ST_FULL))

    // a full report carries the full count
    `ASSERT_IMPL(a_full_count, clk, rst_n, rsp_valid && (rsp_status == drt_pkg::ST_FULL),
                 rsp_entry_count == CAPACITY[drt_pkg::COUNT_W-1:0])

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
                 rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))

endmodule

bind descending_sorted_rank_table drt_checker #(
    .CAPACITY (CAPACITY)
) u_drt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
);

// File: bench/tb.sv
module tb;

    localparam int CAP        = drt_pkg::CAPACITY_DEF;
    localparam int LIMIT      = 600000;
    localparam int DRAIN_WAIT = CAP + 16;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        drt_pkg::status_t              st;
        logic [drt_pkg::COUNT_W-1:0]   cnt;
    } outcome_t;

    typedef struct {
        logic [drt_pkg::MODE_W-1:0]    mode;
        logic [drt_pkg::RANK_W-1:0]    rank;
        logic [drt_pkg::SUIT_W-1:0]    suit;
        bit                            typed;
        drt_pkg::status_t              st;
        logic [drt_pkg::COUNT_W-1:0]   cnt;
    } row_t;

    logic clk;
    logic rst_n;

    drt_cmd_if cmd_bus ();
    drt_rsp_if rsp_bus ();

    descending_sorted_rank_table #(.CAPACITY(CAP)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // predictor state
    logic [drt_pkg::RANK_W-1:0]  held_rank [CAP];
    logic [drt_pkg::SUIT_W-1:0]  held_suit [CAP];
    int                          held_n = 0;

    outcome_t           outcomes_due [$];
    int                 errors = 0;
    int                 cycles = 0;

    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_asked = 0;
    int                 hold_served = 0;

    // typed expectation that travels with the current transaction
    bit                          exp_typed;
    drt_pkg::status_t            exp_st;
    logic [drt_pkg::COUNT_W-1:0] exp_cnt;

    function automatic outcome_t table_apply(logic [drt_pkg::MODE_W-1:0] m,
                                             logic [drt_pkg::RANK_W-1:0] r,
                                             logic [drt_pkg::SUIT_W-1:0] s);
        outcome_t res;
        int pos;
        pos = 0;
        res.st = drt_pkg::ST_DONE;
        if (m == drt_pkg::MODE_INSERT)
        begin
            if (held_n >= CAP)
                res.st = drt_pkg::ST_FULL;
            else
            begin
                while (pos < held_n && held_rank[pos] >= r)
                    pos++;
                for (int k = held_n; k > pos; k--)
                begin
                    held_rank[k] = held_rank[k-1];
                    held_suit[k] = held_suit[k-1];
                end
                held_rank[pos] = r;
                held_suit[pos] = s;
                held_n++;
            end
        end
        else
        begin
            while (pos < held_n && held_rank[pos] != r)
                pos++;
            if (pos >= held_n)
                res.st = drt_pkg::ST_MISS;
            else
            begin
                for (int k = pos; k + 1 < held_n; k++)
                begin
                    held_rank[k] = held_rank[k+1];
                    held_suit[k] = held_suit[k+1];
                end
                held_n--;
            end
        end
        res.cnt = held_n[drt_pkg::COUNT_W-1:0];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // acceptance, prediction and checking
    always @(posedge clk)
    begin
        outcome_t pred;
        outcome_t want;
        if (cmd_bus.valid && cmd_bus.ready)
        begin
            pred = table_apply(cmd_bus.mode, cmd_bus.card_rank, cmd_bus.card_suit);
            if (exp_typed)
            begin
                pred.st  = exp_st;
                pred.cnt = exp_cnt;
            end
            outcomes_due.push_back(pred);
        end
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected response status %0d count %0d", $time,
                         rsp_bus.status, rsp_bus.entry_count);
                errors++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (rsp_bus.status !== want.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.st,
                             rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.entry_count !== want.cnt)
                begin
                    $display("%0t: entry_count expected %0d got %0d", $time, want.cnt,
                             rsp_bus.entry_count);
                    errors++;
                end
            end
        end
    end

    // receiver side
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = HOLD_LEN;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic offer(input row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.mode      <= r.mode;
        cmd_bus.card_rank <= r.rank;
        cmd_bus.card_suit <= r.suit;
        exp_typed         <= r.typed;
        exp_st            <= r.st;
        exp_cnt           <= r.cnt;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
    endtask

    task automatic random_block(input int n, input int ins_pct);
        row_t r;
        int   rv;
        int   sv;
        for (int i = 0; i < n; i++)
        begin
            rv      = $urandom_range(15);
            sv      = $urandom_range(3);
            r.mode  = ($urandom_range(99) < ins_pct) ? drt_pkg::MODE_INSERT
                                                     : drt_pkg::MODE_REMOVE;
            r.rank  = rv[drt_pkg::RANK_W-1:0];
            r.suit  = sv[drt_pkg::SUIT_W-1:0];
            r.typed = 1'b0;
            r.st    = drt_pkg::ST_DONE;
            r.cnt   = '0;
            offer(r);
        end
    endtask

    row_t directed [$];

    function automatic row_t mk(logic [drt_pkg::MODE_W-1:0] m, int rk, int su, int t,
                                drt_pkg::status_t st, int cnt);
        row_t r;
        r.mode  = m;
        r.rank  = rk[drt_pkg::RANK_W-1:0];
        r.suit  = su[drt_pkg::SUIT_W-1:0];
        r.typed = (t != 0);
        r.st    = st;
        r.cnt   = cnt[drt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    initial
    begin
        rst_n             <= 1'b0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.mode      <= drt_pkg::MODE_INSERT;
        cmd_bus.card_rank <= '0;
        cmd_bus.card_suit <= '0;
        exp_typed         <= 1'b0;
        exp_st            <= drt_pkg::ST_DONE;
        exp_cnt           <= '0;

        // empty table, extremes, equal ranks, absent ranks
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  0, 0, 1, drt_pkg::ST_MISS, 0));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 15, 3, 1, drt_pkg::ST_MISS, 0));
        directed.push_back(mk(drt_pkg::MODE_INSERT, 15, 3, 1, drt_pkg::ST_DONE, 1));
        directed.push_back(mk(drt_pkg::MODE_INSERT,  0, 0, 1, drt_pkg::ST_DONE, 2));
        directed.push_back(mk(drt_pkg::MODE_INSERT, 15, 0, 1, drt_pkg::ST_DONE, 3));
        directed.push_back(mk(drt_pkg::MODE_INSERT,  7, 2, 1, drt_pkg::ST_DONE, 4));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  8, 1, 1, drt_pkg::ST_MISS, 4));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 15, 3, 1, drt_pkg::ST_DONE, 3));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 15, 0, 1, drt_pkg::ST_DONE, 2));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 15, 0, 1, drt_pkg::ST_MISS, 2));
        directed.push_back(mk(drt_pkg::MODE_INSERT,  0, 3, 1, drt_pkg::ST_DONE, 3));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  0, 2, 1, drt_pkg::ST_DONE, 2));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  0, 0, 1, drt_pkg::ST_DONE, 1));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  0, 0, 1, drt_pkg::ST_MISS, 1));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  7, 0, 1, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_INSERT, 10, 1, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_INSERT,  5, 2, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_INSERT, 12, 3, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_INSERT, 10, 0, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 10, 1, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_REMOVE,  5, 3, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 12, 0, 0, drt_pkg::ST_DONE, 0));
        directed.push_back(mk(drt_pkg::MODE_REMOVE, 10, 2, 0, drt_pkg::ST_DONE, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer(directed[i]);

        // each phase runs a block of mostly inserts that pushes the table toward full, then a block of mostly removes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default:
                begin
                    send_idle_pct = 8;
                    stall_pct = 8;
                    hold_asked++;
                end
            endcase
            random_block(75, 97);
            random_block(50, 20);
        end

        cmd_bus.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
